// ===== hdl/scc_pkg.sv =====
// Shared types, constants and character-class functions for the syntax color classifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package scc_pkg;

  // Line geometry
  localparam int VisibleWidth = 76;
  localparam int LineLength   = 80;

  // Longest word that is held back for keyword matching
  localparam int WordMax = 6;

  // Command queue between the front and back parts (power of two)
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Color attributes
  localparam logic [3:0] ColPlain   = 4'h7;
  localparam logic [3:0] ColIdent   = 4'hF;
  localparam logic [3:0] ColKeyword = 4'hA;
  localparam logic [3:0] ColMain    = 4'hE;
  localparam logic [3:0] ColDigit   = 4'hB;
  localparam logic [3:0] ColOper    = 4'hC;

  // Column limits; ColumnMax in the column counter's width, the others one bit wider
  localparam logic [6:0] ColumnMax   = 7'd127;
  localparam logic [7:0] StopColumn  = 8'(LineLength - 1);
  localparam logic [7:0] VisibleCol  = 8'(VisibleWidth);

  typedef enum logic [1:0] {
    ModeNone  = 2'd0,
    ModeHeld  = 2'd1,
    ModeLong  = 2'd2,
    ModeDigit = 2'd3
  } scc_mode_e;

  typedef logic [WordMax-1:0][7:0] scc_word_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       line_end;
  } scc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [3:0] color_code;
    logic [6:0] column;
    logic       burst_last;
  } scc_out_t;

  // One burst of results: an optional held word, then an optional single character
  typedef struct packed {
    scc_word_t  word;
    logic [2:0] word_cnt;
    logic [3:0] word_color;
    logic [6:0] word_start;
    logic       has_char;
    logic [7:0] ch;
    logic [3:0] ch_color;
    logic [6:0] ch_column;
  } scc_cmd_t;

  function automatic logic is_lead(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_brace(input logic [7:0] c);
    return c == 8'h7B || c == 8'h7D;
  endfunction

  // Operators: ( ) [ ] ; = + - * / : < > | & ! % ^ ~ @ # ?  (braces also match; the front part colors them apart)
  function automatic logic is_op(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h3B ||
           c == 8'h3D || c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F ||
           c == 8'h3A || c == 8'h3C || c == 8'h3E || c == 8'h7C || c == 8'h26 ||
           c == 8'h21 || c == 8'h25 || c == 8'h5E || c == 8'h7E || c == 8'h40 ||
           c == 8'h23 || c == 8'h3F || is_brace(c);
  endfunction

  // Keyword / main / identifier color of a held word
  function automatic logic [3:0] word_color(input scc_word_t w, input logic [2:0] cnt);
    logic kw3;
    logic kw4;
    logic kw5;
    logic kw6;
    logic is_main;
    kw3 = (w[0] == "i" && w[1] == "n" && w[2] == "t") ||
          (w[0] == "f" && w[1] == "o" && w[2] == "r");
    kw4 = w[0] == "c" && w[1] == "h" && w[2] == "a" && w[3] == "r";
    kw5 = w[0] == "w" && w[1] == "h" && w[2] == "i" && w[3] == "l" && w[4] == "e";
    kw6 = w[0] == "r" && w[1] == "e" && w[2] == "t" && w[3] == "u" && w[4] == "r" &&
          w[5] == "n";
    is_main = w[0] == "m" && w[1] == "a" && w[2] == "i" && w[3] == "n";
    if ((cnt == 3'd3 && kw3) || (cnt == 3'd4 && kw4) || (cnt == 3'd5 && kw5) ||
        (cnt == 3'd6 && kw6)) begin
      return ColKeyword;
    end else if (cnt == 3'd4 && is_main) begin
      return ColMain;
    end
    return ColIdent;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/scc_front.sv =====
// Front part: accepts characters, tracks token state and issues burst commands.
// Depends on scc_pkg.
`default_nettype none

module scc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire scc_pkg::scc_in_t in_i,
  output logic                  cmd_valid_o,
  output scc_pkg::scc_cmd_t     cmd_o
);
  import scc_pkg::*;

  scc_word_t  store_q, store_d;
  logic [2:0] count_q, count_d;
  scc_mode_e  mode_q, mode_d;
  logic [6:0] col_q, col_d;
  logic       stop_q, stop_d;

  logic [7:0] c;
  logic       wordch;
  logic       flush;
  logic       end_flush;
  logic [2:0] flush_cnt;
  logic [3:0] flush_color;
  logic [6:0] flush_start;
  logic       emit;
  logic [3:0] emit_color;

  assign c      = in_i.in_char;
  assign wordch = is_lead(c) || is_digit(c);

  // Classify the character and work out the next token state
  always_comb begin
    store_d     = store_q;
    count_d     = count_q;
    mode_d      = mode_q;
    col_d       = col_q;
    stop_d      = stop_q;
    flush       = 1'b0;
    end_flush   = 1'b0;
    flush_cnt   = count_q;
    flush_color = word_color(store_q, count_q);
    flush_start = col_q - {4'd0, count_q};
    emit        = 1'b0;
    emit_color  = ColPlain;

    if (!stop_q) begin
      if ({1'b0, col_q} >= StopColumn) begin
        flush   = (mode_q == ModeHeld);
        count_d = '0;
        mode_d  = ModeNone;
        stop_d  = 1'b1;
      end else if (mode_q == ModeHeld && wordch) begin
        if (count_q >= 3'(WordMax)) begin
          // Word too long: drop the hold and stream as identifier
          flush       = 1'b1;
          flush_color = ColIdent;
          emit        = 1'b1;
          emit_color  = ColIdent;
          count_d     = '0;
          mode_d      = ModeLong;
        end else begin
          store_d[count_q] = c;
          count_d          = count_q + 3'd1;
        end
      end else if (mode_q == ModeLong && wordch) begin
        emit       = 1'b1;
        emit_color = ColIdent;
      end else if (mode_q == ModeDigit && is_digit(c)) begin
        emit       = 1'b1;
        emit_color = ColDigit;
      end else begin
        flush   = (mode_q == ModeHeld);
        count_d = '0;
        mode_d  = ModeNone;
        if ({1'b0, col_q} >= VisibleCol) begin
          stop_d = 1'b1;
        end else if (is_lead(c)) begin
          store_d[0] = c;
          count_d    = 3'd1;
          mode_d     = ModeHeld;
        end else if (is_digit(c)) begin
          emit       = 1'b1;
          emit_color = ColDigit;
          mode_d     = ModeDigit;
        end else if (is_brace(c)) begin
          emit       = 1'b1;
          emit_color = ColMain;
        end else if (is_op(c)) begin
          emit       = 1'b1;
          emit_color = ColOper;
        end else begin
          emit       = 1'b1;
          emit_color = ColPlain;
        end
      end
      if (col_q < ColumnMax) begin
        col_d = col_q + 7'd1;
      end
    end

    // Line end: release a held word and clear the line state
    if (in_i.line_end) begin
      if (!stop_d && mode_d == ModeHeld) begin
        end_flush   = 1'b1;
        flush_cnt   = count_d;
        flush_color = word_color(store_d, count_d);
        flush_start = col_d - {4'd0, count_d};
      end
      count_d = '0;
      mode_d  = ModeNone;
      col_d   = '0;
      stop_d  = 1'b0;
    end
  end

  // Build the command for the back part
  always_comb begin
    cmd_o.word       = store_d;
    cmd_o.word_cnt   = (flush || end_flush) ? flush_cnt : 3'd0;
    cmd_o.word_color = flush_color;
    cmd_o.word_start = flush_start;
    cmd_o.has_char   = emit;
    cmd_o.ch         = c;
    cmd_o.ch_color   = emit_color;
    cmd_o.ch_column  = col_q;
    cmd_valid_o      = accept_i && (flush || end_flush || emit);
  end

  // Token state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= ModeNone;
      col_q   <= '0;
      stop_q  <= 1'b0;
    end else if (accept_i) begin
      count_q <= count_d;
      mode_q  <= mode_d;
      col_q   <= col_d;
      stop_q  <= stop_d;
    end
  end

  // Held word characters
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      store_q <= store_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scc_cmd_fifo.sv =====
// Short command queue between the front and back parts.
// Depends on scc_pkg.
`default_nettype none

module scc_cmd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire scc_pkg::scc_cmd_t wr_data_i,
  input  wire logic              rd_i,
  output logic                   full_o,
  output logic                   empty_o,
  output scc_pkg::scc_cmd_t      rd_data_o
);
  import scc_pkg::*;

  scc_cmd_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q;
  logic                  do_wr, do_rd;

  assign full_o    = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/scc_back.sv =====
// Back part: expands each command into colored results, one per cycle unless pop stalls, into an output register.
// Depends on scc_pkg.
`default_nettype none

module scc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_empty_i,
  input  wire scc_pkg::scc_cmd_t cmd_i,
  output logic                   cmd_rd_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output scc_pkg::scc_out_t      out_o
);
  import scc_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       valid_q;
  scc_out_t   out_q;
  scc_out_t   res;
  logic [2:0] total;
  logic       is_word;
  logic       load;

  assign total   = cmd_i.word_cnt + {2'd0, cmd_i.has_char};
  assign is_word = idx_q < cmd_i.word_cnt;
  assign load    = !cmd_empty_i && (!valid_q || pop_i);

  // Pick the current result of the head command
  always_comb begin
    if (is_word) begin
      res.out_char   = cmd_i.word[idx_q];
      res.color_code = cmd_i.word_color;
      res.column     = cmd_i.word_start + {4'd0, idx_q};
    end else begin
      res.out_char   = cmd_i.ch;
      res.color_code = cmd_i.ch_color;
      res.column     = cmd_i.ch_column;
    end
    res.burst_last = (idx_q == total - 3'd1);
    cmd_rd_o       = load && res.burst_last;
    idx_d          = idx_q;
    if (load) begin
      idx_d = res.burst_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign empty_o = !valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

// ===== hdl/syntax_color_classifier.sv =====
// Syntax color classifier: top level joining front part, command queue and back part.
// Depends on scc_pkg, scc_front, scc_cmd_fifo and scc_back.
//
// Usage:
//   Input queue side: drive in_i (character and line-end mark) with push; a request is
//   taken at a clock edge with push high and full low. One character per cycle is taken
//   as long as the command queue has room.
//   Result queue side: while empty is low, out_o holds the oldest result (character,
//   color, column, burst_last); pop takes it. burst_last marks the last result of an input.
//   Path: a character that gives a result at once is written to the command queue, then
//   loaded into the back part's output register, from which it can be popped.
//   Held words leave when the word ends, one result per cycle while pop keeps up.
//   Throughput: one result per cycle while pop is high, set by the back part's output
//   register; a request that releases a held word gives up to seven results, and the
//   two-entry command queue absorbs such bursts. Requests that give no result write
//   no command to the queue.
//   Stall: with pop low, the result holds; the queue fills and full rises to hold push.
//   Reset: clears token state, column, queue and output valid flag; the block is empty and not full.
`default_nettype none

module syntax_color_classifier (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire scc_pkg::scc_in_t  in_i,
  output logic                   empty,
  input  wire logic              pop,
  output scc_pkg::scc_out_t      out_o
);
  import scc_pkg::*;

  logic     accept;
  logic     cmd_valid;
  scc_cmd_t cmd_wr;
  scc_cmd_t cmd_head;
  logic     cmd_rd;
  logic     cmd_empty;

  assign accept = push && !full;

  scc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr)
  );

  scc_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wr_data_i (cmd_wr),
    .rd_i      (cmd_rd),
    .full_o    (full),
    .empty_o   (cmd_empty),
    .rd_data_o (cmd_head)
  );

  scc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_rd_o    (cmd_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== hdl/scc_checker.sv =====
// Port-level checker for the syntax color classifier, bound to the top level.
// Depends on scc_pkg and syntax_color_classifier.
`default_nettype none

module scc_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  input  wire logic              full,
  input  wire scc_pkg::scc_in_t  in_i,
  input  wire logic              empty,
  input  wire logic              pop,
  input  wire scc_pkg::scc_out_t out_o
);
  import scc_pkg::*;

  // Reset leaves the result side empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result side not empty after reset");

  // Reset leaves the input side open
  a_reset_open: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("input side full after reset");

  // Hold a waiting result until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("waiting result changed");

  // Within a burst the next result follows at once, one column further
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !out_o.burst_last |=>
      !empty && out_o.column == $past(out_o.column) + 7'd1)
    else $error("burst broken or column not consecutive");

endmodule

bind syntax_color_classifier scc_checker u_scc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .in_i   (in_i),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

`default_nettype wire

// ===== test/syntax_color_classifier_tb.sv =====
// Testbench for syntax_color_classifier: random source lines in, colored characters out.
// Depends on scc_pkg for the request and result types and the color and line constants.
`timescale 1ns / 1ps

module syntax_color_classifier_tb;
  import scc_pkg::*;

  // Track token state per line and hold the colored characters still to come
  class color_checker;
    scc_out_t   pending_colors[$];
    scc_out_t   cur_burst[$];
    logic [7:0] held_chars[WordMax];
    logic [2:0] held_count;
    scc_mode_e  mode;
    logic [6:0] line_col;
    bit         line_halted;
    int         errors;
    int         checked;

    function new();
      errors  = 0;
      checked = 0;
      reset_line();
    endfunction

    function void reset_line();
      held_count  = '0;
      mode        = ModeNone;
      line_col    = '0;
      line_halted = 1'b0;
    endfunction

    function bit starts_word(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_symbol_char(logic [7:0] c);
      string ops;
      ops = "()[];=+-*/:<>|&!%^~@#?";
      for (int i = 0; i < ops.len(); i++) begin
        if (ops[i] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Keyword, main or plain identifier, from the held characters
    function logic [3:0] held_color();
      logic [47:0] word;
      word = '0;
      for (int k = 0; k < held_count; k++) word = {word[39:0], held_chars[k]};
      if ((held_count == 3 && (word == "int" || word == "for")) ||
          (held_count == 4 && word == "char") || (held_count == 5 && word == "while") ||
          (held_count == 6 && word == "return")) begin
        return ColKeyword;
      end
      if (held_count == 4 && word == "main") return ColMain;
      return ColIdent;
    endfunction

    function void emit(logic [7:0] c, logic [3:0] color, logic [6:0] col);
      cur_burst.push_back('{out_char: c, color_code: color, column: col, burst_last: 1'b0});
    endfunction

    // Release the held word; its last character sat just left of end_col
    function void emit_held(logic [6:0] end_col, logic [3:0] color);
      logic [6:0] start;
      start = end_col - 7'(held_count);
      for (int k = 0; k < held_count; k++) emit(held_chars[k], color, start + 7'(k));
      held_count = '0;
      mode       = ModeNone;
    endfunction

    // Advance the line state by one accepted request and queue its colored characters
    function void note_char(scc_in_t req);
      logic [7:0] c;
      logic [6:0] col;
      bit         wordch;
      c   = req.in_char;
      col = line_col;
      cur_burst.delete();
      if (!line_halted) begin
        wordch = starts_word(c) || is_numeral(c);
        if (col >= LineLength - 1) begin
          // Too long: end the line here
          if (mode == ModeHeld) emit_held(col, held_color());
          mode        = ModeNone;
          line_halted = 1'b1;
        end else if (mode == ModeHeld && wordch) begin
          if (held_count >= WordMax) begin
            emit_held(col, ColIdent);
            emit(c, ColIdent, col);
            mode = ModeLong;
          end else begin
            held_chars[held_count] = c;
            held_count++;
          end
        end else if (mode == ModeLong && wordch) begin
          emit(c, ColIdent, col);
        end else if (mode == ModeDigit && is_numeral(c)) begin
          emit(c, ColDigit, col);
        end else begin
          // A new token starts here, unless the visible width is used up
          if (mode == ModeHeld) emit_held(col, held_color());
          mode = ModeNone;
          if (col >= VisibleWidth) begin
            line_halted = 1'b1;
          end else if (starts_word(c)) begin
            held_chars[0] = c;
            held_count    = 3'd1;
            mode          = ModeHeld;
          end else if (is_numeral(c)) begin
            emit(c, ColDigit, col);
            mode = ModeDigit;
          end else if (c == "{" || c == "}") begin
            emit(c, ColMain, col);
          end else if (is_symbol_char(c)) begin
            emit(c, ColOper, col);
          end else begin
            emit(c, ColPlain, col);
          end
        end
        if (line_col != ColumnMax) line_col++;
      end
      if (req.line_end) begin
        if (!line_halted && mode == ModeHeld) emit_held(line_col, held_color());
        reset_line();
      end
      if (cur_burst.size() > 0) cur_burst[cur_burst.size() - 1].burst_last = 1'b1;
      foreach (cur_burst[i]) pending_colors.push_back(cur_burst[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH %s", msg);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_color(scc_out_t got);
      scc_out_t want;
      checked++;
      if (pending_colors.size() == 0) begin
        report($sformatf("unexpected result char %02h column %0d", got.out_char, got.column));
        return;
      end
      want = pending_colors.pop_front();
      if (got.out_char !== want.out_char)
        report($sformatf("char %02h, want %02h", got.out_char, want.out_char));
      if (got.color_code !== want.color_code)
        report($sformatf("color %0h, want %0h for char %02h col %0d", got.color_code,
                         want.color_code, want.out_char, want.column));
      if (got.column !== want.column)
        report($sformatf("column %0d, want %0d", got.column, want.column));
      if (got.burst_last !== want.burst_last)
        report($sformatf("burst_last %0b, want %0b at column %0d", got.burst_last,
                         want.burst_last, want.column));
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  scc_in_t  in_i;
  logic     empty;
  logic     pop;
  scc_out_t out_o;

  int           send_idle;
  int           recv_idle;
  bit           hold_request;
  byte unsigned line_buf[$];
  int           sent;
  int           lines;
  int           long_lines;
  color_checker board = new();

  syntax_color_classifier dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (in_i),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Sample both handshakes with the values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_char(in_i);
      if (pop && !empty) board.check_color(out_o);
    end
  end

  // Offer one character and hold it until the block takes it
  task send_char(input logic [7:0] c, input bit last);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= '{in_char: c, line_end: last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  task send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    lines++;
  endtask

  // Build a line of mostly well-formed tokens with some noise, cut to target characters
  task make_line(input int target);
    string kw_list[6];
    string ops;
    string w;
    int    n;
    int    r;
    kw_list = '{"int", "char", "while", "for", "return", "main"};
    ops     = "{}()[];=+-*/:<>|&!%^~@#?";
    line_buf.delete();
    while (line_buf.size() < target) begin
      case ($urandom_range(9))
        0: begin
          w = kw_list[$urandom_range(5)];
          for (int i = 0; i < w.len(); i++) line_buf.push_back(w[i]);
        end
        1, 2: begin
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) begin
            r = (i > 0 && $urandom_range(3) == 0) ? 60 : $urandom_range(52);
            if (r < 26) line_buf.push_back(8'("a" + r));
            else if (r < 52) line_buf.push_back(8'("A" + r - 26));
            else if (r == 52) line_buf.push_back("_");
            else line_buf.push_back(8'("0" + $urandom_range(9)));
          end
        end
        3: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) line_buf.push_back(8'("0" + $urandom_range(9)));
        end
        4, 5: line_buf.push_back(ops[$urandom_range(ops.len() - 1)]);
        6, 7: line_buf.push_back(" ");
        8: line_buf.push_back(8'($urandom_range(1, 255)));
        default: begin
          // Near miss of a keyword: one short or one long
          w = kw_list[$urandom_range(5)];
          n = $urandom_range(1) ? w.len() - 1 : w.len();
          for (int i = 0; i < n; i++) line_buf.push_back(w[i]);
          if (n == w.len()) line_buf.push_back("_");
        end
      endcase
    end
    while (line_buf.size() > target) void'(line_buf.pop_back());
  endtask

  // Drain results; hold off for a long stretch when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    string directed;
    int    goal;
    int    guard;
    push         = 1'b0;
    pop          = 1'b0;
    in_i         = '0;
    rst_ni       = 1'b0;
    send_idle    = 29;
    recv_idle    = 69;
    hold_request = 1'b0;
    sent         = 0;
    lines        = 0;
    long_lines   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Keywords, main, braces, operators and digits, then high and low codes
    directed = "int main(){return 12;}";
    line_buf.delete();
    for (int i = 0; i < directed.len(); i++) line_buf.push_back(directed[i]);
    send_line();
    line_buf = '{8'hFF, 8'h80, 8'h01};
    send_line();

    // Three idling phases; in the first, one long line reaches the visible width and may reach the line limit
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 29 : (phase == 1) ? 69 : 0;
      recv_idle = (phase == 0) ? 69 : (phase == 1) ? 29 : 0;
      if (phase == 2) hold_request = 1'b1;
      if (phase == 0) begin
        make_line($urandom_range(77, 86));
        send_line();
        long_lines++;
      end
      goal = sent + 15;
      while (sent < goal) begin
        make_line($urandom_range(1, 18));
        send_line();
      end
    end
    push <= 1'b0;

    // Wait for the last results, and go on waiting for stray ones
    recv_idle = 0;
    for (guard = 0; guard < 20000 && board.pending_colors.size() != 0; guard++)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.pending_colors.size() != 0)
      board.report($sformatf("%0d results never arrived", board.pending_colors.size()));

    $display("Sent %0d characters in %0d lines (%0d past the visible width).", sent, lines,
             long_lines);
    $display("Compared %0d colored results, with idle, stall and hold-off phases.",
             board.checked);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/scc_pkg.sv
hdl/scc_front.sv
hdl/scc_cmd_fifo.sv
hdl/scc_back.sv
hdl/syntax_color_classifier.sv
hdl/scc_checker.sv
test/syntax_color_classifier_tb.sv
